// ----- rtl/vn2d_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn2d_pkg
// Shared widths, hash constants and pipeline depth of the 2-D value noise core.
// ----------------------------------------------------------------------------
package vn2d_pkg;

    // Fixed-point formats
    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int VALUE_BITS = 24;
    localparam int SEED_BITS  = 32;

    // Derived widths
    localparam int POLY_BITS = FRAC_BITS + 2;               // 3*2^F - 2f
    localparam int DIFF_BITS = VALUE_BITS + 1;              // signed corner difference
    localparam int PROD_BITS = DIFF_BITS + FRAC_BITS + 1;   // difference times weight

    // Number of register stages from request to result
    localparam int NUM_STAGES = 9;

    // Lattice hash constants
    localparam logic [31:0] HASH_MUL_X  = 32'h9e3779b9;
    localparam logic [31:0] HASH_MUL_Z  = 32'h85ebca6b;
    localparam logic [31:0] HASH_ADD_Z  = 32'h7f4a7c15;
    localparam logic [31:0] HASH_MUL_S  = 32'hc2b2ae35;
    localparam logic [31:0] HASH_ADD_S  = 32'h165667b1;
    localparam logic [31:0] HASH_MIX_A  = 32'h7feb352d;
    localparam logic [31:0] HASH_MIX_B  = 32'h846ca68b;

    // Smoothstep constant 3 * 2^F
    localparam logic [POLY_BITS-1:0] POLY_THREE = POLY_BITS'(3) << FRAC_BITS;

endpackage

// ----- rtl/vn2d_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn2d_if
// Valid/ready channels of the value noise core: sample requests in, noise out.
// ----------------------------------------------------------------------------
interface vn2d_in_if;
    logic                                       valid;
    logic                                       ready;
    logic signed [vn2d_pkg::COORD_BITS-1:0]     sample_x;
    logic signed [vn2d_pkg::COORD_BITS-1:0]     sample_z;
    logic signed [vn2d_pkg::SEED_BITS-1:0]      noise_seed;

    modport source (output valid, output sample_x, output sample_z, output noise_seed,
                    input ready);
    modport sink   (input valid, input sample_x, input sample_z, input noise_seed,
                    output ready);
endinterface

interface vn2d_out_if;
    logic                               valid;
    logic                               ready;
    logic [vn2d_pkg::VALUE_BITS-1:0]    noise_value;

    modport source (output valid, output noise_value, input ready);
    modport sink   (input valid, input noise_value, output ready);
endinterface

// ----- rtl/value_noise_2d_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// value_noise_2d_core
// Smoothstep-weighted bilinear value noise over a hashed 2-D integer lattice.
// ----------------------------------------------------------------------------
// The core takes one sample request (x, z in signed Q16.16, 32-bit seed) per
// clock unless stalled by output back-pressure, and returns one Q0.24 noise
// value per request, in request order. It is a nine-stage pipeline: a request
// passes through the stage registers in order and its result is offered from
// the stage 9 output register; with the output ready, the sustained rate is
// one sample per cycle. The depth is set by the chain of three 32x32
// hash multiplies per corner followed by the two dependent blend multiplies
// (both rows, then z), each multiply followed by its own register. Each
// stage holds its item only while the stage after it is full and stalled,
// so back-pressure on the output does not stop empty stages from filling.
// ----------------------------------------------------------------------------
module value_noise_2d_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    vn2d_in_if.sink         i_smp,
    vn2d_out_if.source      o_noise
);

    localparam int FB = vn2d_pkg::FRAC_BITS;
    localparam int VB = vn2d_pkg::VALUE_BITS;
    localparam int NS = vn2d_pkg::NUM_STAGES;

    // Stage valid bits and load enables
    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_en;

    // Stage 1: cell products and weight squares
    logic [31:0]                        r1_hx, r1_hz, r1_hs;
    logic [FB-1:0]                      r1_sqx, r1_sqz;
    logic [vn2d_pkg::POLY_BITS-1:0]     r1_polyx, r1_polyz;
    // Stage 2: first hash mix, weights
    logic [31:0]                        r2_h [4];
    logic [FB-1:0]                      r2_wx, r2_wz;
    // Stage 3 and 4: hash multiplies
    logic [31:0]                        r3_h [4];
    logic [31:0]                        r4_h [4];
    logic [FB-1:0]                      r3_wx, r3_wz, r4_wx, r4_wz;
    // Stage 5: corner values and x differences
    logic [VB-1:0]                      r5_v00, r5_v01;
    logic signed [vn2d_pkg::DIFF_BITS-1:0] r5_d0, r5_d1;
    logic [FB-1:0]                      r5_wx, r5_wz;
    // Stage 6: x products
    logic [VB-1:0]                      r6_v00, r6_v01;
    logic signed [vn2d_pkg::PROD_BITS-1:0] r6_p0, r6_p1;
    logic [FB-1:0]                      r6_wz;
    // Stage 7: rows and z difference
    logic [VB-1:0]                      r7_row0;
    logic signed [vn2d_pkg::DIFF_BITS-1:0] r7_dz;
    logic [FB-1:0]                      r7_wz;
    // Stage 8: z product
    logic [VB-1:0]                      r8_row0;
    logic signed [vn2d_pkg::PROD_BITS-1:0] r8_pz;
    // Stage 9: output register
    logic [VB-1:0]                      r9_res;

    // Stage enables: a stage loads when empty or when its content moves on
    always_comb begin
        n_en[NS-1] = !r_vld[NS-1] || o_noise.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            n_en[k] = !r_vld[k] || n_en[k+1];
        end
    end

    assign i_smp.ready       = n_en[0];
    assign o_noise.valid     = r_vld[NS-1];
    assign o_noise.noise_value = r9_res;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_en[0]) begin
                r_vld[0] <= i_smp.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (n_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 1: floor to cells, take fractions, start hash and weight products
    logic [31:0]    s1_x0, s1_z0;
    logic [FB-1:0]  s1_fx, s1_fz;

    always_comb begin
        s1_x0 = 32'(i_smp.sample_x >>> FB);
        s1_z0 = 32'(i_smp.sample_z >>> FB);
        s1_fx = i_smp.sample_x[FB-1:0];
        s1_fz = i_smp.sample_z[FB-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (n_en[0]) begin
            r1_hx    <= 32'(s1_x0 * vn2d_pkg::HASH_MUL_X);
            r1_hz    <= 32'(s1_z0 * vn2d_pkg::HASH_MUL_Z);
            r1_hs    <= 32'(i_smp.noise_seed * vn2d_pkg::HASH_MUL_S);
            r1_sqx   <= FB'(({{FB{1'b0}}, s1_fx} * {{FB{1'b0}}, s1_fx}) >> FB);
            r1_sqz   <= FB'(({{FB{1'b0}}, s1_fz} * {{FB{1'b0}}, s1_fz}) >> FB);
            r1_polyx <= vn2d_pkg::POLY_THREE - {1'b0, s1_fx, 1'b0};
            r1_polyz <= vn2d_pkg::POLY_THREE - {1'b0, s1_fz, 1'b0};
        end
    end

    // Stage 2: combine cell terms per corner, fold high half; finish weights
    logic [31:0] s2_hx [2];
    logic [31:0] s2_hz [2];
    logic [31:0] s2_hs;
    logic [31:0] s2_h  [4];
    logic [FB+vn2d_pkg::POLY_BITS-1:0] s2_wxp, s2_wzp;

    always_comb begin
        s2_hx[0] = r1_hx;
        s2_hx[1] = r1_hx + vn2d_pkg::HASH_MUL_X;
        s2_hz[0] = r1_hz + vn2d_pkg::HASH_ADD_Z;
        s2_hz[1] = r1_hz + 32'(vn2d_pkg::HASH_MUL_Z + vn2d_pkg::HASH_ADD_Z);
        s2_hs    = r1_hs + vn2d_pkg::HASH_ADD_S;
        for (int c = 0; c < 4; c++) begin
            s2_h[c] = s2_hx[c % 2] ^ s2_hz[c / 2] ^ s2_hs;
            s2_h[c] = s2_h[c] ^ (s2_h[c] >> 16);
        end
        s2_wxp = {{vn2d_pkg::POLY_BITS{1'b0}}, r1_sqx} * {{FB{1'b0}}, r1_polyx};
        s2_wzp = {{vn2d_pkg::POLY_BITS{1'b0}}, r1_sqz} * {{FB{1'b0}}, r1_polyz};
    end

    always_ff @(posedge i_clk) begin
        if (n_en[1]) begin
            r2_h  <= s2_h;
            r2_wx <= s2_wxp[2*FB-1:FB];
            r2_wz <= s2_wzp[2*FB-1:FB];
        end
    end

    // Stage 3: first avalanche multiply
    always_ff @(posedge i_clk) begin
        if (n_en[2]) begin
            for (int c = 0; c < 4; c++) begin
                r3_h[c] <= 32'(r2_h[c] * vn2d_pkg::HASH_MIX_A);
            end
            r3_wx <= r2_wx;
            r3_wz <= r2_wz;
        end
    end

    // Stage 4: fold and second avalanche multiply
    always_ff @(posedge i_clk) begin
        if (n_en[3]) begin
            for (int c = 0; c < 4; c++) begin
                r4_h[c] <= 32'((r3_h[c] ^ (r3_h[c] >> 15)) * vn2d_pkg::HASH_MIX_B);
            end
            r4_wx <= r3_wx;
            r4_wz <= r3_wz;
        end
    end

    // Stage 5: final fold, corner values, differences along x
    logic [31:0]   s5_h [4];
    logic [VB-1:0] s5_v [4];

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            s5_h[c] = r4_h[c] ^ (r4_h[c] >> 16);
            s5_v[c] = s5_h[c][VB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en[4]) begin
            r5_v00 <= s5_v[0];
            r5_v01 <= s5_v[2];
            r5_d0  <= $signed({1'b0, s5_v[1]}) - $signed({1'b0, s5_v[0]});
            r5_d1  <= $signed({1'b0, s5_v[3]}) - $signed({1'b0, s5_v[2]});
            r5_wx  <= r4_wx;
            r5_wz  <= r4_wz;
        end
    end

    // Stage 6: scale x differences by the x weight
    always_ff @(posedge i_clk) begin
        if (n_en[5]) begin
            r6_p0  <= r5_d0 * $signed({1'b0, r5_wx});
            r6_p1  <= r5_d1 * $signed({1'b0, r5_wx});
            r6_v00 <= r5_v00;
            r6_v01 <= r5_v01;
            r6_wz  <= r5_wz;
        end
    end

    // Stage 7: rows (floored products), then their difference along z
    logic signed [vn2d_pkg::PROD_BITS-1:0] s7_q0, s7_q1;
    logic signed [vn2d_pkg::DIFF_BITS-1:0] s7_row0, s7_row1;

    always_comb begin
        s7_q0   = r6_p0 >>> FB;
        s7_q1   = r6_p1 >>> FB;
        s7_row0 = $signed({1'b0, r6_v00}) + $signed(s7_q0[vn2d_pkg::DIFF_BITS-1:0]);
        s7_row1 = $signed({1'b0, r6_v01}) + $signed(s7_q1[vn2d_pkg::DIFF_BITS-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (n_en[6]) begin
            r7_row0 <= s7_row0[VB-1:0];
            r7_dz   <= $signed({1'b0, s7_row1[VB-1:0]}) - $signed({1'b0, s7_row0[VB-1:0]});
            r7_wz   <= r6_wz;
        end
    end

    // Stage 8: scale z difference by the z weight
    always_ff @(posedge i_clk) begin
        if (n_en[7]) begin
            r8_pz   <= r7_dz * $signed({1'b0, r7_wz});
            r8_row0 <= r7_row0;
        end
    end

    // Stage 9: final blend into the output register
    logic signed [vn2d_pkg::PROD_BITS-1:0] s9_q;
    logic signed [vn2d_pkg::DIFF_BITS-1:0] s9_res;

    always_comb begin
        s9_q   = r8_pz >>> FB;
        s9_res = $signed({1'b0, r8_row0}) + $signed(s9_q[vn2d_pkg::DIFF_BITS-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (n_en[8]) begin
            r9_res <= s9_res[VB-1:0];
        end
    end

`ifndef SYNTHESIS
    // An empty first stage always takes a request
    a_empty_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[0] |-> i_smp.ready)
        else $error("first stage empty but request refused");

    // A request taken with no result leaving adds exactly one item in flight
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_smp.valid && i_smp.ready && !(o_noise.valid && o_noise.ready))
        |=> $countones(r_vld) == $past($countones(r_vld)) + 1)
        else $error("accepted request lost or duplicated");

    // A result leaving with no request taken removes exactly one item
    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!(i_smp.valid && i_smp.ready) && o_noise.valid && o_noise.ready)
        |=> $countones(r_vld) == $past($countones(r_vld)) - 1)
        else $error("delivered result not retired or item invented");
`endif

endmodule
